// File: rtl/date_time_field_adjust_unit_macros.svh
// Assertion helpers for the date/time setting block.
`ifndef DATE_TIME_FIELD_ADJUST_UNIT_MACROS_SVH
`define DATE_TIME_FIELD_ADJUST_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define DTFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, held off during reset.
`define DTFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DTFA_ASSERT_NOW(lbl, ante, cons, msg)
`define DTFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/dtfa_pkg.sv
package dtfa_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_NEXT = 2'd1,
    MODE_INC  = 2'd2,
    MODE_DEC  = 2'd3
  } dtfa_mode_t;

  localparam logic [2:0] CUR_YEAR   = 3'd0;
  localparam logic [2:0] CUR_MONTH  = 3'd1;
  localparam logic [2:0] CUR_DAY    = 3'd2;
  localparam logic [2:0] CUR_HOUR   = 3'd3;
  localparam logic [2:0] CUR_MINUTE = 3'd4;
  localparam logic [2:0] CUR_SECOND = 3'd5;
  localparam int unsigned FIELD_COUNT = 6;

  // Full clock/calendar state plus the field cursor.
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] cursor;
  } dtfa_fields_t;

endpackage

// File: rtl/date_time_field_adjust_unit.sv
// Setting logic of a two-digit calendar clock. Each command transfer
// (mode plus load fields) updates the year/month/day/hour/minute/second
// state and the field cursor, and produces exactly one result carrying the
// full state after the command. One command is taken every clock cycle
// while cmd_ready is high; the next-state logic is a single short
// wrap-and-compare pass between the state register and the result
// buffer, which registers each result. The output side is a two-entry
// buffer, so a command is still taken while one finished result waits
// on res_ready; cmd_ready drops only when both entries are full.
`include "date_time_field_adjust_unit_macros.svh"

module date_time_field_adjust_unit
  import dtfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [1:0] mode,
  input  logic [6:0] load_year,
  input  logic [3:0] load_month,
  input  logic [4:0] load_day,
  input  logic [4:0] load_hour,
  input  logic [5:0] load_minute,
  input  logic [5:0] load_second,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [6:0] year,
  output logic [3:0] month,
  output logic [4:0] day,
  output logic [4:0] hour,
  output logic [5:0] minute,
  output logic [5:0] second,
  output logic [2:0] cursor
);

  dtfa_fields_t state;
  dtfa_fields_t state_next;
  dtfa_fields_t load;
  dtfa_fields_t res;
  logic         accept;
  logic         spill_valid;

  assign accept = cmd_valid && cmd_ready;

  // Pack the load fields; cursor is forced to the year by the step logic.
  always_comb begin
    load.year   = load_year;
    load.month  = load_month;
    load.day    = load_day;
    load.hour   = load_hour;
    load.minute = load_minute;
    load.second = load_second;
    load.cursor = CUR_YEAR;
  end

  dtfa_step u_step (
    .mode (dtfa_mode_t'(mode)),
    .load (load),
    .cur  (state),
    .nxt  (state_next)
  );

  // Advance the state on every command transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.year   <= 7'd0;
      state.month  <= 4'd1;
      state.day    <= 5'd1;
      state.hour   <= 5'd0;
      state.minute <= 6'd0;
      state.second <= 6'd0;
      state.cursor <= CUR_YEAR;
    end else if (accept) begin
      state <= state_next;
    end
  end

  dtfa_skid u_skid (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_data   (state_next),
    .push_ready  (cmd_ready),
    .pop_valid   (res_valid),
    .pop_ready   (res_ready),
    .pop_data    (res),
    .spill_valid (spill_valid)
  );

  assign year   = res.year;
  assign month  = res.month;
  assign day    = res.day;
  assign hour   = res.hour;
  assign minute = res.minute;
  assign second = res.second;
  assign cursor = res.cursor;

  // A parked result never exists without one in the output slot.
  `DTFA_ASSERT_NOW(a_spill_has_main, spill_valid, res_valid, "spill entry without main entry")
  // The cursor only ever walks the six fields.
  `DTFA_ASSERT_NOW(a_cursor_range, 1'b1, state.cursor < 3'(FIELD_COUNT), "cursor out of range")
  // A load always returns the cursor to the year.
  `DTFA_ASSERT_NEXT(a_load_cursor, accept && (mode == MODE_LOAD), state.cursor == CUR_YEAR,
                    "load left cursor off year")

endmodule

// File: rtl/dtfa_step.sv
module dtfa_step
  import dtfa_pkg::*;
(
  input  dtfa_mode_t   mode,
  input  dtfa_fields_t load,
  input  dtfa_fields_t cur,
  output dtfa_fields_t nxt
);

  // Signed wrap: above hi goes to lo, below lo goes to hi.
  function automatic logic [6:0] wrap(input logic signed [8:0] s,
                                      input logic signed [8:0] lo,
                                      input logic signed [8:0] hi);
    logic signed [8:0] r;
    if (s > hi) r = lo;
    else if (s < lo) r = hi;
    else r = s;
    return r[6:0];
  endfunction

  function automatic logic signed [8:0] bump(input logic [6:0] v, input logic hit,
                                             input logic down);
    logic signed [8:0] d;
    d = hit ? (down ? -9'sd1 : 9'sd1) : 9'sd0;
    return $signed({2'b00, v}) + d;
  endfunction

  logic             down;
  logic [6:0]       yr_w;
  logic [6:0]       mo_w;
  logic [6:0]       dy_w;
  logic [6:0]       hr_w;
  logic [6:0]       mi_w;
  logic [6:0]       se_w;
  logic [4:0]       mlen;
  logic [3:0]       cur_inc;

  assign down = (mode == MODE_DEC);

  always_comb begin
    yr_w = wrap(bump(cur.year, cur.cursor == CUR_YEAR, down), 9'sd0, 9'sd99);
    mo_w = wrap(bump({3'b000, cur.month}, cur.cursor == CUR_MONTH, down), 9'sd1, 9'sd12);
    unique case (mo_w[3:0])
      4'd2:                      mlen = (yr_w[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  mlen = 5'd30;
      default:                   mlen = 5'd31;
    endcase
    dy_w = wrap(bump({2'b00, cur.day}, cur.cursor == CUR_DAY, down), 9'sd1,
                $signed({4'b0000, mlen}));
    hr_w = wrap(bump({2'b00, cur.hour}, cur.cursor == CUR_HOUR, down), 9'sd0, 9'sd23);
    mi_w = wrap(bump({1'b0, cur.minute}, cur.cursor == CUR_MINUTE, down), 9'sd0, 9'sd59);
    se_w = wrap(bump({1'b0, cur.second}, cur.cursor == CUR_SECOND, down), 9'sd0, 9'sd59);

    cur_inc = {1'b0, cur.cursor} + 4'd1;
    if (cur_inc >= 4'(FIELD_COUNT)) cur_inc = cur_inc - 4'(FIELD_COUNT);

    nxt = cur;
    unique case (mode)
      MODE_LOAD: begin
        nxt        = load;
        nxt.cursor = CUR_YEAR;
      end
      MODE_NEXT: begin
        nxt.cursor = cur_inc[2:0];
      end
      MODE_INC, MODE_DEC: begin
        nxt.year   = yr_w;
        nxt.month  = mo_w[3:0];
        nxt.day    = dy_w[4:0];
        nxt.hour   = hr_w[4:0];
        nxt.minute = mi_w[5:0];
        nxt.second = se_w[5:0];
      end
      default: nxt = cur;
    endcase
  end

endmodule

// File: rtl/dtfa_skid.sv
module dtfa_skid
  import dtfa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  dtfa_fields_t push_data,
  output logic         push_ready,
  output logic         pop_valid,
  input  logic         pop_ready,
  output dtfa_fields_t pop_data,
  output logic         spill_valid
);

  logic         main_valid;
  dtfa_fields_t main_data;
  logic         skid_valid;
  dtfa_fields_t skid_data;
  logic         take;

  assign take        = main_valid && pop_ready;
  assign push_ready  = !skid_valid;
  assign pop_valid   = main_valid;
  assign pop_data    = main_data;
  assign spill_valid = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || take) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
        if (push) main_data <= push_data;
      end
    end else if (push) begin
      // Main slot stalled: park the new result.
      skid_data  <= push_data;
      skid_valid <= 1'b1;
    end
  end

endmodule
